// ===== design/asat_pkg.sv =====
// Shared constants, codes and types for the AP station auth/assoc table.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package asat_pkg;

    // Table geometry
    localparam int STATIONS = 32;
    localparam int IDX_W    = (STATIONS > 1) ? $clog2(STATIONS) : 1;

    // Field widths
    localparam int REQ_W    = 3;
    localparam int ADDR_W   = 48;
    localparam int SEQ_W    = 16;
    localparam int KIND_W   = 3;
    localparam int NOTIFY_W = 2;
    localparam int ST_W     = 2;

    // Configuration port
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;
    localparam logic REG_FOUR_STEP_AUTH = 1'b0;   // word index of the only register

    // Request types
    localparam logic [REQ_W-1:0] REQ_AUTH     = 3'd0;
    localparam logic [REQ_W-1:0] REQ_DEAUTH   = 3'd1;
    localparam logic [REQ_W-1:0] REQ_ASSOC    = 3'd2;
    localparam logic [REQ_W-1:0] REQ_REASSOC  = 3'd3;
    localparam logic [REQ_W-1:0] REQ_DISASSOC = 3'd4;

    // Response frame kinds
    localparam logic [KIND_W-1:0] FRAME_NONE       = 3'd0;
    localparam logic [KIND_W-1:0] FRAME_AUTH_OK    = 3'd1;
    localparam logic [KIND_W-1:0] FRAME_AUTH_FINAL = 3'd2;
    localparam logic [KIND_W-1:0] FRAME_AUTH_OOS   = 3'd3;
    localparam logic [KIND_W-1:0] FRAME_NOT_AUTH   = 3'd4;
    localparam logic [KIND_W-1:0] FRAME_ASSOC_OK   = 3'd5;
    localparam logic [KIND_W-1:0] FRAME_REASSOC_OK = 3'd6;

    // Notifications
    localparam logic [NOTIFY_W-1:0] NOTIFY_NONE  = 2'd0;
    localparam logic [NOTIFY_W-1:0] NOTIFY_ASSOC = 2'd1;
    localparam logic [NOTIFY_W-1:0] NOTIFY_LOST  = 2'd2;

    // Station status
    localparam logic [ST_W-1:0] ST_NOT_AUTH = 2'd0;
    localparam logic [ST_W-1:0] ST_AUTH     = 2'd1;
    localparam logic [ST_W-1:0] ST_ASSOC    = 2'd2;

    // Auth exchange lengths, one bit wider than the sequence to catch wrap
    localparam logic [SEQ_W:0] AUTH_STEPS_FOUR = 17'd4;
    localparam logic [SEQ_W:0] AUTH_STEPS_TWO  = 17'd2;
    localparam logic [SEQ_W-1:0] SEQ_FIRST     = 16'd1;
    localparam logic [SEQ_W-1:0] SEQ_STRIDE    = 16'd2;

    // One station table entry
    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [ST_W-1:0]   status;
        logic [SEQ_W-1:0]  exp_seq;
    } t_entry;

    // Controller to datapath commands
    typedef struct packed {
        logic start;    // capture a request, restart the scan
        logic scan;     // read one table entry and advance
        logic decide;   // compute the response and update the table
        logic load;     // move the response into the output register
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic scan_last;   // current read is the last table entry
        logic out_free;    // output register can take a response
    } t_dp_stat;

endpackage

// ===== design/asat_if.sv =====
// Request and response channel interfaces of the AP station auth/assoc table.
// Depends on asat_pkg for field widths.
`timescale 1ns / 1ps

interface asat_req_if import asat_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [REQ_W-1:0]  req_type;
    logic [ADDR_W-1:0] sta_addr;
    logic [SEQ_W-1:0]  auth_seq;

    modport source (output valid, output req_type, output sta_addr, output auth_seq,
                    input ready);
    modport sink   (input valid, input req_type, input sta_addr, input auth_seq,
                    output ready);
endinterface

interface asat_resp_if import asat_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [KIND_W-1:0]   frame_kind;
    logic [SEQ_W-1:0]    resp_seq;
    logic [ADDR_W-1:0]   dest_addr;
    logic [NOTIFY_W-1:0] notify;
    logic                table_full;

    modport source (output valid, output frame_kind, output resp_seq, output dest_addr,
                    output notify, output table_full, input ready);
    modport sink   (input valid, input frame_kind, input resp_seq, input dest_addr,
                    input notify, input table_full, output ready);
endinterface

// ===== design/asat_ctrl.sv =====
// Controller of the station table: sequences capture, table scan, decision and
// response hand-off. Depends on asat_pkg for the command and status structs.
`timescale 1ns / 1ps

module asat_ctrl import asat_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_SCAN   = 5'b00010,
        S_DRAIN  = 5'b00100,
        S_DECIDE = 5'b01000,
        S_OUT    = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    // Next state and commands
    always_comb begin
        n_state      = r_state;
        o_cmd        = '0;
        o_in_ready   = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready  = 1'b1;
                o_cmd.start = i_in_valid;
                if (i_in_valid) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_stat.scan_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_DECIDE;
            end
            S_DECIDE: begin
                o_cmd.decide = 1'b1;
                n_state      = S_OUT;
            end
            S_OUT: begin
                if (i_stat.out_free) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== design/asat_dp.sv =====
// Datapath of the station table: request capture, station memory with valid
// bits, sequential address search, response decision and output register.
// Depends on asat_pkg for widths, codes and the command and status structs.
`timescale 1ns / 1ps

module asat_dp import asat_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_dp_cmd             i_cmd,
    output t_dp_stat            o_stat,
    input  logic                i_four_step,
    input  logic [REQ_W-1:0]    i_req_type,
    input  logic [ADDR_W-1:0]   i_sta_addr,
    input  logic [SEQ_W-1:0]    i_auth_seq,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [KIND_W-1:0]   o_frame_kind,
    output logic [SEQ_W-1:0]    o_resp_seq,
    output logic [ADDR_W-1:0]   o_dest_addr,
    output logic [NOTIFY_W-1:0] o_notify,
    output logic                o_table_full
);

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(STATIONS - 1);

    // Captured request
    logic [REQ_W-1:0]  r_req_type;
    logic [ADDR_W-1:0] r_sta_addr;
    logic [SEQ_W-1:0]  r_auth_seq;

    // Station table
    t_entry             r_mem [STATIONS];
    logic [STATIONS-1:0] r_valid;

    // Scan pipeline
    logic [IDX_W-1:0] r_idx;
    t_entry           r_rd_entry;
    logic [IDX_W-1:0] r_rd_idx;
    logic             r_rd_live;

    // Search results
    logic             r_found;
    logic [IDX_W-1:0] r_hit_idx;
    logic [ST_W-1:0]  r_hit_status;
    logic [SEQ_W-1:0] r_hit_seq;
    logic             r_free_found;
    logic [IDX_W-1:0] r_free_idx;

    // Decided response
    logic [KIND_W-1:0]   r_res_kind;
    logic [SEQ_W-1:0]    r_res_seq;
    logic [NOTIFY_W-1:0] r_res_notify;
    logic                r_res_full;

    // Output register
    logic                r_out_valid;
    logic [KIND_W-1:0]   r_out_kind;
    logic [SEQ_W-1:0]    r_out_seq;
    logic [ADDR_W-1:0]   r_out_addr;
    logic [NOTIFY_W-1:0] r_out_notify;
    logic                r_out_full;

    logic                hit_now;
    logic                free_now;
    logic [KIND_W-1:0]   n_kind;
    logic [SEQ_W-1:0]    n_rseq;
    logic [NOTIFY_W-1:0] n_notify;
    logic                n_full;
    logic                wr_en;
    logic [IDX_W-1:0]    wr_idx;
    t_entry              wr_entry;
    logic [ST_W-1:0]     st0;
    logic [SEQ_W-1:0]    ex0;
    logic [SEQ_W:0]      seq_inc;
    logic                is_last;
    logic                do_write;

    assign o_stat.scan_last = (r_idx == LAST_IDX);
    assign o_stat.out_free  = !r_out_valid || i_out_ready;

    // Capture the request
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_req_type <= i_req_type;
            r_sta_addr <= i_sta_addr;
            r_auth_seq <= i_auth_seq;
        end
    end

    // Station memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_idx] <= wr_entry;
        end
        if (i_cmd.scan) begin
            r_rd_entry <= r_mem[r_idx];
        end
    end

    // Valid bits, cleared at reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (wr_en) begin
            r_valid[wr_idx] <= 1'b1;
        end
    end

    // Compare the entry read last cycle; note the first free slot on issue
    assign hit_now  = r_rd_live && r_valid[r_rd_idx] && (r_rd_entry.addr == r_sta_addr);
    assign free_now = i_cmd.scan && !r_valid[r_idx];

    // Advance the scan and collect hit and free slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx        <= '0;
            r_rd_live    <= 1'b0;
            r_found      <= 1'b0;
            r_free_found <= 1'b0;
        end else if (i_cmd.start) begin
            r_idx        <= '0;
            r_rd_live    <= 1'b0;
            r_found      <= 1'b0;
            r_free_found <= 1'b0;
        end else begin
            r_rd_live <= i_cmd.scan;
            if (i_cmd.scan && !o_stat.scan_last) begin
                r_idx <= r_idx + 1'b1;
            end
            if (hit_now && !r_found) begin
                r_found <= 1'b1;
            end
            if (free_now && !r_free_found) begin
                r_free_found <= 1'b1;
            end
        end
    end

    // Hold the payload of the hit and free slot
    always_ff @(posedge i_clk) begin
        if (i_cmd.scan) begin
            r_rd_idx <= r_idx;
        end
        if (hit_now && !r_found) begin
            r_hit_idx    <= r_rd_idx;
            r_hit_status <= r_rd_entry.status;
            r_hit_seq    <= r_rd_entry.exp_seq;
        end
        if (free_now && !r_free_found) begin
            r_free_idx <= r_idx;
        end
    end

    // Decide the response and the table update
    always_comb begin
        n_kind   = FRAME_NONE;
        n_rseq   = '0;
        n_notify = NOTIFY_NONE;
        n_full   = 1'b0;
        do_write = 1'b0;
        st0      = r_found ? r_hit_status : ST_NOT_AUTH;
        ex0      = r_found ? r_hit_seq : SEQ_FIRST;
        seq_inc  = {1'b0, r_auth_seq} + 1'b1;
        is_last  = 1'b0;
        case (r_req_type)
            REQ_AUTH: begin
                if (!r_found && !r_free_found) begin
                    n_full = 1'b1;
                end else begin
                    do_write = 1'b1;
                    // sequence one restarts the exchange
                    if (r_auth_seq == SEQ_FIRST) begin
                        if (st0 == ST_ASSOC) begin
                            n_notify = NOTIFY_LOST;
                        end
                        st0 = ST_NOT_AUTH;
                        ex0 = SEQ_FIRST;
                    end
                    if (r_auth_seq != ex0) begin
                        n_kind = FRAME_AUTH_OOS;
                        ex0    = SEQ_FIRST;
                    end else begin
                        is_last = (seq_inc == (i_four_step ? AUTH_STEPS_FOUR
                                                           : AUTH_STEPS_TWO));
                        n_kind  = is_last ? FRAME_AUTH_FINAL : FRAME_AUTH_OK;
                        n_rseq  = seq_inc[SEQ_W-1:0];
                        if (is_last) begin
                            if (st0 == ST_ASSOC) begin
                                n_notify = NOTIFY_LOST;
                            end
                            st0 = ST_AUTH;
                        end else begin
                            ex0 = ex0 + SEQ_STRIDE;
                        end
                    end
                end
            end
            REQ_DEAUTH, REQ_DISASSOC: begin
                if (r_found) begin
                    do_write = 1'b1;
                    if (st0 == ST_ASSOC) begin
                        n_notify = NOTIFY_LOST;
                    end
                    if (r_req_type == REQ_DEAUTH) begin
                        st0 = ST_NOT_AUTH;
                        ex0 = SEQ_FIRST;
                    end else begin
                        st0 = ST_AUTH;
                    end
                end
            end
            REQ_ASSOC, REQ_REASSOC: begin
                if (!r_found || st0 == ST_NOT_AUTH) begin
                    n_kind = FRAME_NOT_AUTH;
                end else begin
                    do_write = 1'b1;
                    if (r_req_type == REQ_ASSOC && st0 != ST_ASSOC) begin
                        n_notify = NOTIFY_ASSOC;
                    end
                    st0    = ST_ASSOC;
                    n_kind = (r_req_type == REQ_ASSOC) ? FRAME_ASSOC_OK : FRAME_REASSOC_OK;
                end
            end
            default: begin
                // unknown request: no effect
            end
        endcase
        wr_entry.addr    = r_sta_addr;
        wr_entry.status  = st0;
        wr_entry.exp_seq = ex0;
    end

    assign wr_en  = i_cmd.decide && do_write;
    assign wr_idx = r_found ? r_hit_idx : r_free_idx;

    // Hold the decided response
    always_ff @(posedge i_clk) begin
        if (i_cmd.decide) begin
            r_res_kind   <= n_kind;
            r_res_seq    <= n_rseq;
            r_res_notify <= n_notify;
            r_res_full   <= n_full;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_out_kind   <= r_res_kind;
            r_out_seq    <= r_res_seq;
            r_out_addr   <= (r_res_kind != FRAME_NONE) ? r_sta_addr : '0;
            r_out_notify <= r_res_notify;
            r_out_full   <= r_res_full;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_frame_kind = r_out_kind;
    assign o_resp_seq   = r_out_seq;
    assign o_dest_addr  = r_out_addr;
    assign o_notify     = r_out_notify;
    assign o_table_full = r_out_full;

endmodule

// ===== design/ap_station_auth_assoc_table.sv =====
// Top level of the AP station auth/assoc table: configuration register,
// controller and datapath. Depends on asat_pkg, asat_if, asat_ctrl, asat_dp.
`timescale 1ns / 1ps

// One request is taken at a time. After acceptance the block scans its station
// memory one entry per cycle to find the sender address and the lowest free
// slot, then decides the response and updates the entry. The response reaches
// the output register through these steps in order: the scan of every entry,
// a compare of the last entry read, the decision with the table write, and the
// load of the output register. The next request is accepted in the cycle after
// the response is loaded, even while that response still waits to be taken; a
// response that is not taken stalls the following request only at its
// hand-off. No clearing pass is needed after reset: per-entry valid bits are
// cleared at once. The register four_step_auth sits at byte address 0; the user
// must write it only while the block is idle: the block does not enforce this.

module ap_station_auth_assoc_table import asat_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    asat_req_if.sink           i_req,
    asat_resp_if.source        o_resp,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [APB_AW-1:0]  paddr,
    input  logic [APB_DW-1:0]  pwdata,
    output logic [APB_DW-1:0]  prdata,
    output logic               pready
);

    logic     r_four_step;
    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;
    logic     cfg_wr;

    // Configuration register
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready
                    && (paddr[APB_AW-1] == REG_FOUR_STEP_AUTH);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_four_step <= 1'b1;
        end else if (cfg_wr) begin
            r_four_step <= pwdata[0];
        end
    end

    // Register read back
    always_comb begin
        prdata = '0;
        unique case (paddr[APB_AW-1])
            REG_FOUR_STEP_AUTH: prdata = {{(APB_DW-1){1'b0}}, r_four_step};
            default:            prdata = '0;
        endcase
    end

    asat_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (i_req.ready),
        .i_stat     (dp_stat),
        .o_cmd      (dp_cmd)
    );

    asat_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (dp_cmd),
        .o_stat       (dp_stat),
        .i_four_step  (r_four_step),
        .i_req_type   (i_req.req_type),
        .i_sta_addr   (i_req.sta_addr),
        .i_auth_seq   (i_req.auth_seq),
        .o_out_valid  (o_resp.valid),
        .i_out_ready  (o_resp.ready),
        .o_frame_kind (o_resp.frame_kind),
        .o_resp_seq   (o_resp.resp_seq),
        .o_dest_addr  (o_resp.dest_addr),
        .o_notify     (o_resp.notify),
        .o_table_full (o_resp.table_full)
    );

endmodule

// ===== design/asat_chk.sv =====
// Port-level checker for the AP station auth/assoc table, bound to the top level.
// Depends on asat_pkg for frame kind and notification codes.
`timescale 1ns / 1ps

module asat_chk import asat_pkg::*; (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_valid,
    input logic                i_ready,
    input logic [KIND_W-1:0]   i_frame_kind,
    input logic [SEQ_W-1:0]    i_resp_seq,
    input logic [ADDR_W-1:0]   i_dest_addr,
    input logic [NOTIFY_W-1:0] i_notify,
    input logic                i_table_full
);

    // Hold a stalled response
    a_resp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_frame_kind) && $stable(i_dest_addr))
        else $error("response dropped or changed while stalled");

    // No frame means no destination
    a_no_frame_no_dest: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_frame_kind == FRAME_NONE |-> i_dest_addr == '0)
        else $error("destination set without a response frame");

    // Only accepted auth steps carry a sequence
    a_seq_only_auth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_resp_seq != '0 |->
            i_frame_kind == FRAME_AUTH_OK || i_frame_kind == FRAME_AUTH_FINAL)
        else $error("response sequence on a non-auth frame");

    // A full table yields nothing else
    a_full_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_table_full |-> i_frame_kind == FRAME_NONE && i_notify == NOTIFY_NONE)
        else $error("table full with a response or notification");

    // New association comes only with an assoc response
    a_assoc_notify: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_notify == NOTIFY_ASSOC |-> i_frame_kind == FRAME_ASSOC_OK)
        else $error("association notice without assoc response");

endmodule

bind ap_station_auth_assoc_table asat_chk u_asat_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_valid      (o_resp.valid),
    .i_ready      (o_resp.ready),
    .i_frame_kind (o_resp.frame_kind),
    .i_resp_seq   (o_resp.resp_seq),
    .i_dest_addr  (o_resp.dest_addr),
    .i_notify     (o_resp.notify),
    .i_table_full (o_resp.table_full)
);
